// ===== rtl/hsb_pkg.sv =====
// types, codes and helpers shared by the horizontal scroll blit sequencer
package hsb_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgAddrW-3:0] RegScrollLines = '0;
  localparam logic [7:0] ScrollLinesRst = 8'd212;
  localparam logic [3:0] FramesPerStep = 4'd8;
  localparam logic [7:0] EdgeX = 8'd248;
  localparam logic [8:0] BandWidth = 9'd248;
  localparam logic [7:0] ColumnX = 8'd8;
  localparam logic [8:0] ColumnWidth = 9'd8;
  localparam logic [8:0] FullWidth = 9'd256;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_DISPLAY = 2'd1,
    KIND_COPY    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // one classified request, handed from the front to the back
  typedef struct packed {
    op_e        op;
    logic [7:0] x;
    logic       page;
    logic [3:0] fine_adjust;
    logic [7:0] y;
    logic       has_band;
    logic       has_edge;
    logic       dir_neg;
  } job_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  fine_adjust;
    logic        shown_page;
    logic [7:0]  src_x;
    logic [8:0]  src_y;
    logic [8:0]  copy_width;
    logic [7:0]  copy_height;
    logic [7:0]  dst_x;
    logic [8:0]  dst_y;
    logic        last;
  } res_t;

  // band height is the scroll height divided by eight, rounded up
  function automatic logic [5:0] band_height(input logic [7:0] lines);
    logic [8:0] sum;
    sum = {1'b0, lines} + 9'd7;
    return sum[8:3];
  endfunction

endpackage

// ===== rtl/hsb_if.sv =====
// request and result channel interfaces
interface hsb_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] position;

  modport source (output valid, mode, position, input ready);
  modport sink (input valid, mode, position, output ready);
endinterface

interface hsb_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [3:0] fine_adjust;
  logic              shown_page;
  logic [7:0]        src_x;
  logic [8:0]        src_y;
  logic [8:0]        copy_width;
  logic [7:0]        copy_height;
  logic [7:0]        dst_x;
  logic [8:0]        dst_y;
  logic              last;

  modport source (output valid, kind, fine_adjust, shown_page, src_x, src_y, copy_width,
                  copy_height, dst_x, dst_y, last, input ready);
  modport sink (input valid, kind, fine_adjust, shown_page, src_x, src_y, copy_width,
                copy_height, dst_x, dst_y, last, output ready);
endinterface

// ===== rtl/hsb_front.sv =====
// front end: accepts requests, keeps the scroll state and classifies each request into a job
module hsb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_mode_i,
  input  logic [7:0]    req_position_i,
  output logic          req_ready_o,
  input  logic [7:0]    scroll_lines_i,
  output logic          job_valid_o,
  output hsb_pkg::job_t job_o,
  input  logic          job_ready_i
);
  import hsb_pkg::*;

  logic [7:0] cur_pos_q, cur_pos_d;
  logic [4:0] coarse_q, coarse_d;
  logic [2:0] fine_q, fine_d;
  logic [4:0] dir_q, dir_d;
  logic [3:0] frames_q, frames_d;
  logic       page_q, page_d;

  logic       accept;
  logic [4:0] next_coarse;
  logic [4:0] step;
  logic       pos_chg, coarse_chg, rotate;
  logic [3:0] frames_dec;
  logic       active;
  logic [5:0] band;
  logic [8:0] prod;

  assign req_ready_o = job_ready_i;
  assign job_valid_o = req_valid_i;
  assign accept      = req_valid_i && job_ready_i;

  assign next_coarse = req_position_i[7:3];
  // 5-bit difference is the step already wrapped to -16..15
  assign step        = next_coarse - coarse_q;
  assign pos_chg     = req_position_i != cur_pos_q;
  assign coarse_chg  = next_coarse != coarse_q;
  assign rotate      = pos_chg && coarse_chg && (step != dir_q);

  assign frames_dec  = frames_q - 4'd1;
  assign active      = frames_q != 4'd0;
  assign band        = band_height(scroll_lines_i);
  assign prod        = {6'b0, frames_dec[2:0]} * {3'b0, band};

  always_comb begin
    job_o = '0;
    if (req_mode_i == 1'b0) begin
      job_o.op   = rotate ? OP_ROTATE : OP_IDLE;
      job_o.x    = {step, 3'b000};
      job_o.page = page_q;
    end else begin
      job_o.op          = OP_TICK;
      job_o.page        = coarse_q[0];
      job_o.fine_adjust = 4'(5'd16 - {2'b00, fine_q});
      job_o.y           = prod[7:0];
      job_o.has_band    = active && (dir_q != 5'd0);
      job_o.has_edge    = active && (dir_q != 5'd0) && (frames_dec == 4'd0);
      job_o.dir_neg     = dir_q[4];
    end
  end

  always_comb begin
    cur_pos_d = cur_pos_q;
    coarse_d  = coarse_q;
    fine_d    = fine_q;
    dir_d     = dir_q;
    frames_d  = frames_q;
    page_d    = page_q;
    if (accept) begin
      if (req_mode_i == 1'b0) begin
        if (pos_chg) begin
          if (coarse_chg) begin
            dir_d    = step;
            frames_d = FramesPerStep;
          end
          fine_d    = req_position_i[2:0];
          coarse_d  = next_coarse;
          cur_pos_d = req_position_i;
        end
      end else begin
        page_d = coarse_q[0];
        if (active) begin
          frames_d = frames_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pos_q <= '0;
      coarse_q  <= '0;
      fine_q    <= '0;
      dir_q     <= '0;
      frames_q  <= '0;
      page_q    <= 1'b0;
    end else begin
      cur_pos_q <= cur_pos_d;
      coarse_q  <= coarse_d;
      fine_q    <= fine_d;
      dir_q     <= dir_d;
      frames_q  <= frames_d;
      page_q    <= page_d;
    end
  end

endmodule

// ===== rtl/hsb_queue.sv =====
// small job queue between the front and the back
module hsb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  hsb_pkg::job_t push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output hsb_pkg::job_t pop_data_o,
  input  logic          pop_ready_i
);
  import hsb_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full    = CntW'(Depth);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != Full;
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/hsb_back.sv =====
// back end: jobs become results in the output register, one a cycle unless stalled
module hsb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  hsb_pkg::job_t job_i,
  output logic          job_ready_o,
  input  logic [7:0]    scroll_lines_i,
  output logic          res_valid_o,
  output hsb_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import hsb_pkg::*;

  logic [1:0] step_q, step_d;
  logic       res_valid_q, res_valid_d;
  res_t       res_q;
  res_t       r;
  logic       load;
  logic [5:0] band;
  logic [7:0] x;
  logic       sp, dp;

  assign band = band_height(scroll_lines_i);

  always_comb begin
    r  = '0;
    r.kind = KIND_IDLE;
    // second half of a rotation works on the other page with the mirrored cut
    x  = step_q[1] ? 8'(8'd0 - job_i.x) : job_i.x;
    sp = job_i.page ^ step_q[1];
    dp = ~sp;
    unique case (job_i.op)
      OP_ROTATE: begin
        r.kind        = KIND_COPY;
        r.src_y       = {sp, 8'h00};
        r.dst_y       = {dp, 8'h00};
        r.copy_height = scroll_lines_i;
        if (step_q[0] == 1'b0) begin
          r.src_x      = x;
          r.copy_width = FullWidth - {1'b0, x};
          r.dst_x      = 8'h00;
        end else begin
          r.src_x      = 8'h00;
          r.copy_width = {1'b0, x};
          r.dst_x      = 8'(8'd0 - x);
        end
        r.last = step_q == 2'd3;
      end
      OP_TICK: begin
        if (step_q == 2'd0) begin
          r.kind        = KIND_DISPLAY;
          r.fine_adjust = job_i.fine_adjust;
          r.shown_page  = job_i.page;
          r.last        = !job_i.has_band;
        end else if (step_q == 2'd1) begin
          // band copy that shifts one strip of the hidden page
          r.kind        = KIND_COPY;
          r.src_x       = job_i.dir_neg ? 8'h00 : ColumnX;
          r.dst_x       = job_i.dir_neg ? ColumnX : 8'h00;
          r.copy_width  = BandWidth;
          r.copy_height = {2'b00, band};
          r.src_y       = {job_i.page, 8'h00} + {1'b0, job_i.y};
          r.dst_y       = {~job_i.page, 8'h00} + {1'b0, job_i.y};
          r.last        = !job_i.has_edge;
        end else begin
          // edge column on the final frame of the countdown
          r.kind        = KIND_COPY;
          r.src_x       = job_i.dir_neg ? EdgeX : 8'h00;
          r.dst_x       = job_i.dir_neg ? 8'h00 : EdgeX;
          r.copy_width  = ColumnWidth;
          r.copy_height = scroll_lines_i;
          r.src_y       = {job_i.page, 8'h00};
          r.dst_y       = {~job_i.page, 8'h00};
          r.last        = 1'b1;
        end
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
  end

  assign load        = job_valid_i && (!res_valid_q || res_ready_i);
  assign job_ready_o = load && r.last;

  always_comb begin
    step_d      = step_q;
    res_valid_d = res_valid_q;
    if (load) begin
      step_d      = r.last ? 2'd0 : step_q + 2'd1;
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= r;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/bitmap_hscroll_blit_sequencer_top.sv =====
// top level of the horizontal scroll blit sequencer with its register port
// the first result of a request goes through the job queue, then the output register
// the back end's output register gives one result a cycle unless the receiver stalls;
//   a request gives 1 result (idle), 1 to 3 (frame tick) or 4 (page rotation)
// requests keep being taken while the job queue has room
// reset clears the scroll state and output valid, scroll_lines returns to 212
module bitmap_hscroll_blit_sequencer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hsb_req_if.sink                       req_i,
  hsb_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [hsb_pkg::CfgDataW-1:0]  pwdata,
  output logic [hsb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import hsb_pkg::*;

  logic [7:0] scroll_lines_q;
  logic       reg_hit;
  logic       fe_valid, fe_ready;
  job_t       fe_job;
  logic       be_valid, be_ready;
  job_t       be_job;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_hit = paddr[CfgAddrW-1:2] == RegScrollLines;
  assign prdata  = reg_hit ? {{(CfgDataW-8){1'b0}}, scroll_lines_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_lines_q <= ScrollLinesRst;
    end else if (psel && penable && pwrite && reg_hit) begin
      scroll_lines_q <= pwdata[7:0];
    end
  end

  hsb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_mode_i     (req_i.mode),
    .req_position_i (req_i.position),
    .req_ready_o    (req_i.ready),
    .scroll_lines_i (scroll_lines_q),
    .job_valid_o    (fe_valid),
    .job_o          (fe_job),
    .job_ready_i    (fe_ready)
  );

  hsb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_data_i  (fe_job),
    .push_ready_o (fe_ready),
    .pop_valid_o  (be_valid),
    .pop_data_o   (be_job),
    .pop_ready_i  (be_ready)
  );

  hsb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (be_valid),
    .job_i          (be_job),
    .job_ready_o    (be_ready),
    .scroll_lines_i (scroll_lines_q),
    .res_valid_o    (res_o.valid),
    .res_o          (res),
    .res_ready_i    (res_o.ready)
  );

  assign res_o.kind        = res.kind;
  assign res_o.fine_adjust = res.fine_adjust;
  assign res_o.shown_page  = res.shown_page;
  assign res_o.src_x       = res.src_x;
  assign res_o.src_y       = res.src_y;
  assign res_o.copy_width  = res.copy_width;
  assign res_o.copy_height = res.copy_height;
  assign res_o.dst_x       = res.dst_x;
  assign res_o.dst_y       = res.dst_y;
  assign res_o.last        = res.last;

endmodule

// ===== rtl/hsb_checker.sv =====
// port-level checks for the sequencer top, bound onto it
module hsb_checker #(
  parameter int unsigned MaxOpen = 3
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [8:0] res_src_y,
  input logic [8:0] res_dst_y,
  input logic       res_last
);
  import hsb_pkg::*;

  localparam int unsigned OpenW = $clog2(MaxOpen + 2);

  // requests taken whose last result has not yet gone out
  logic [OpenW-1:0] open_q, open_d;
  logic             req_acc, done_acc;

  assign req_acc  = req_valid && req_ready;
  assign done_acc = res_valid && res_ready && res_last;

  always_comb begin
    open_d = open_q;
    if (req_acc && !done_acc) begin
      open_d = open_q + 1'b1;
    end else if (done_acc && !req_acc) begin
      open_d = open_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_last)
      && $stable(res_src_y) && $stable(res_dst_y))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> open_q != '0)
    else $error("result shown with no request open");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= OpenW'(MaxOpen))
    else $error("more requests open than the queue and output stage can hold");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == KIND_IDLE |-> res_last)
    else $error("idle result not marked as final");

endmodule

bind bitmap_hscroll_blit_sequencer_top hsb_checker #(
  .MaxOpen (QueueDepth + 1)
) u_hsb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_kind  (res_o.kind),
  .res_src_y (res_o.src_y),
  .res_dst_y (res_o.dst_y),
  .res_last  (res_o.last)
);

// ===== test/testbench.sv =====
// testbench for the horizontal scroll blit sequencer: random and directed requests, checked results
`timescale 1ns / 1ps

module testbench;
  import hsb_pkg::*;

  localparam int HoldCycles = 120;
  localparam int PhaseItems = 55;

  typedef struct {
    logic       mode;
    logic [7:0] position;
  } scroll_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  hsb_req_if req_if ();
  hsb_res_if res_if ();

  bitmap_hscroll_blit_sequencer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mirror of the scroll state
  logic [7:0] lines       = ScrollLinesRst;
  logic [7:0] cur_pos     = '0;
  logic [4:0] coarse      = '0;
  logic [2:0] fine        = '0;
  int         step_dir    = 0;
  logic [3:0] frames_left = '0;
  logic       disp_page   = 1'b0;

  scroll_req_t scroll_reqs[$];
  res_t        due_results[$];
  int          mismatches = 0;
  logic [7:0]  gen_pos = '0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int          holds_asked = 0;
  int          holds_done = 0;

  function automatic res_t make_copy(input int sx, input int sy, input int w, input int h,
                                     input int dx, input int dy);
    res_t r;
    r = '0;
    r.kind        = KIND_COPY;
    r.src_x       = sx[7:0];
    r.src_y       = sy[8:0];
    r.copy_width  = w[8:0];
    r.copy_height = h[7:0];
    r.dst_x       = dx[7:0];
    r.dst_y       = dy[8:0];
    return r;
  endfunction

  // two copies swap the halves split at x from one page onto the other
  function automatic void add_rotation(ref res_t outs[$], input int x, input logic sp,
                                       input logic dp);
    int y1;
    int y2;
    y1 = 256 * int'(sp);
    y2 = 256 * int'(dp);
    outs.push_back(make_copy(x, y1, int'(FullWidth) - x, int'(lines), 0, y2));
    outs.push_back(make_copy(0, y1, x, int'(lines), int'(FullWidth) - x, y2));
  endfunction

  task automatic step_scroll(input logic mode, input logic [7:0] pos);
    res_t       outs[$];
    res_t       r;
    logic [4:0] nc;
    int         d;
    int         band;
    int         y;
    int         y1;
    int         y2;
    if (mode == 1'b0) begin
      if (pos != cur_pos) begin
        nc = pos[7:3];
        if (nc != coarse) begin
          d = int'(nc) - int'(coarse);
          if (d < -16) begin
            d += 32;
          end else if (d > 15) begin
            d -= 32;
          end
          if (d != step_dir) begin
            add_rotation(outs, (8 * (d + 32)) & 255, disp_page, !disp_page);
            add_rotation(outs, (8 * (32 - d)) & 255, !disp_page, disp_page);
            step_dir = d;
          end
          frames_left = FramesPerStep;
        end
        fine    = pos[2:0];
        coarse  = nc;
        cur_pos = pos;
      end
      if (outs.size() == 0) begin
        r = '0;
        r.kind = KIND_IDLE;
        outs.push_back(r);
      end
    end else begin
      band = (int'(lines) + 7) / 8;
      disp_page = coarse[0];
      r = '0;
      r.kind        = KIND_DISPLAY;
      r.fine_adjust = 4'd0 - {1'b0, fine};
      r.shown_page  = disp_page;
      outs.push_back(r);
      if (frames_left != 0) begin
        frames_left = frames_left - 4'd1;
        y  = int'(frames_left) * band;
        y1 = 256 * int'(disp_page);
        y2 = 256 - y1;
        if (step_dir > 0) begin
          outs.push_back(make_copy(int'(ColumnX), y1 + y, int'(BandWidth), band, 0, y2 + y));
        end else if (step_dir < 0) begin
          outs.push_back(make_copy(0, y1 + y, int'(BandWidth), band, int'(ColumnX), y2 + y));
        end
        // edge column only on the final frame of the countdown
        if (frames_left == 0) begin
          if (step_dir > 0) begin
            outs.push_back(make_copy(0, y1, int'(ColumnWidth), int'(lines), int'(EdgeX), y2));
          end else if (step_dir < 0) begin
            outs.push_back(make_copy(int'(EdgeX), y1, int'(ColumnWidth), int'(lines), 0, y2));
          end
        end
      end
    end
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) due_results.push_back(outs[i]);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d", $time, res_if.kind);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    check_field("kind", int'(want.kind), int'(res_if.kind));
    check_field("fine_adjust", int'(want.fine_adjust), int'(unsigned'(res_if.fine_adjust)));
    check_field("shown_page", int'(want.shown_page), int'(res_if.shown_page));
    check_field("src_x", int'(want.src_x), int'(res_if.src_x));
    check_field("src_y", int'(want.src_y), int'(res_if.src_y));
    check_field("copy_width", int'(want.copy_width), int'(res_if.copy_width));
    check_field("copy_height", int'(want.copy_height), int'(res_if.copy_height));
    check_field("dst_x", int'(want.dst_x), int'(res_if.dst_x));
    check_field("dst_y", int'(want.dst_y), int'(res_if.dst_y));
    check_field("last", int'(want.last), int'(res_if.last));
  endfunction

  // request driver
  int          send_wait;
  scroll_req_t next_req;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_wait    <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        step_scroll(req_if.mode, req_if.position);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0) begin
          send_wait    <= send_wait - 1;
          req_if.valid <= 1'b0;
        end else if (scroll_reqs.size() != 0) begin
          next_req = scroll_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.mode     <= next_req.mode;
          req_if.position <= next_req.position;
          send_wait       <= send_calm ? 0 : $urandom_range(0, 3);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stalls
  int stall_left;
  int hold_left;
  always @(posedge clk_i) begin
    int pause;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      pause = 0;
      if (res_if.valid && res_if.ready) begin
        check_result();
        if (!recv_calm) pause = $urandom_range(0, 3);
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done   <= holds_done + 1;
        hold_left    <= HoldCycles;
        res_if.ready <= 1'b0;
      end else if (pause != 0) begin
        stall_left   <= pause - 1;
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegScrollLines, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_lines(input logic [7:0] value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = $urandom();
    wdata[7:0] = value;
    apb_xfer(1'b1, wdata, rdata);
    lines = value;
    apb_xfer(1'b0, '0, rdata);
    if (rdata[7:0] != lines) begin
      $display("%0t: scroll_lines readback mismatch, expected %0d, actual %0d",
               $time, lines, rdata[7:0]);
      mismatches++;
    end
  endtask

  task automatic queue_req(input logic mode, input logic [7:0] pos);
    scroll_req_t r;
    r.mode     = mode;
    r.position = pos;
    scroll_reqs.push_back(r);
  endtask

  // mostly moves followed by a run of frame ticks, with some noise mixed in
  task automatic queue_random(input int count);
    int made;
    int pick;
    int ticks;
    made = 0;
    while (made < count) begin
      pick  = $urandom_range(0, 9);
      ticks = 0;
      if (pick < 6) begin
        queue_req(1'b0, gen_pos + 8'($urandom_range(0, 48)) - 8'd24);
        ticks = $urandom_range(1, 9);
      end else if (pick < 8) begin
        queue_req(1'b0, 8'($urandom()));
      end else if (pick == 8) begin
        queue_req(1'b0, gen_pos);
      end else begin
        queue_req(1'b1, 8'($urandom()));
      end
      if (scroll_reqs[$].mode == 1'b0) gen_pos = scroll_reqs[$].position;
      made++;
      repeat (ticks) begin
        queue_req(1'b1, 8'($urandom()));
        made++;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (scroll_reqs.size() != 0 || req_if.valid || due_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] rdata;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = 1'b0;
    req_if.position = '0;
    res_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    apb_xfer(1'b0, '0, rdata);
    if (rdata[7:0] != ScrollLinesRst) begin
      $display("%0t: scroll_lines after reset, expected %0d, actual %0d",
               $time, ScrollLinesRst, rdata[7:0]);
      mismatches++;
    end
    write_lines(ScrollLinesRst);

    // tick before any move, unchanged and fine-only moves, then a step right
    queue_req(1'b1, 8'hff);
    queue_req(1'b0, 8'd0);
    queue_req(1'b0, 8'd5);
    queue_req(1'b0, 8'd8);
    repeat (8) queue_req(1'b1, 8'($urandom()));
    // step left with rotation, then a further step the same way
    queue_req(1'b0, 8'd255);
    queue_req(1'b0, 8'd239);
    repeat (8) queue_req(1'b1, 8'($urandom()));
    // largest steps, wrapping to both ends of the signed range
    queue_req(1'b0, 8'd127);
    queue_req(1'b0, 8'd255);
    queue_req(1'b0, 8'd112);
    gen_pos = 8'd112;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_lines(8'd0);
        1: write_lines(8'd1);
        2: write_lines(8'd255);
        3: write_lines(8'($urandom_range(1, 212)));
        4: write_lines(ScrollLinesRst);
        default: write_lines(8'($urandom()));
      endcase
      send_calm = (phase % 3 == 1);
      recv_calm = (phase % 3 == 1);
      queue_random(PhaseItems);
      // receiver holds off while the sender keeps offering
      if (phase == 2) holds_asked++;
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
